### src/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Types, register codes and the quarter-wave sine table shared by the
// periodic waveform cycler.
// ----------------------------------------------------------------------------
`default_nettype none

package pwc_pkg;

  localparam int VALUE_BITS      = 16;
  localparam int TIME_BITS       = 24;
  localparam int FRAC_BITS       = 16;
  localparam int SINE_TABLE_BITS = 8;

  localparam int TAB_N     = 1 << SINE_TABLE_BITS;
  localparam int QTAB_BITS = 31;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_START    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAVEFORM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE   = 3'd4;

  // Waveform codes.
  localparam logic [2:0] WAVE_TRIANGLE = 3'd0;
  localparam logic [2:0] WAVE_SINE     = 3'd1;
  localparam logic [2:0] WAVE_COSINE   = 3'd2;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;
  localparam logic [2:0] WAVE_SQUARE   = 3'd4;

  typedef struct packed {
    logic                 cmd;
    logic [TIME_BITS-1:0] delta;
  } pwc_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] level;
    logic                         falling;
  } pwc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAT,
    ST_DIV,
    ST_QUAD,
    ST_TAB,
    ST_MUL,
    ST_SIN,
    ST_TERM,
    ST_LEVEL,
    ST_COMMIT
  } pwc_state_t;

  typedef struct packed {
    logic load;
    logic sat;
    logic div;
    logic quad;
    logic tab;
    logic mul;
    logic sin;
    logic term;
    logic level;
    logic commit;
  } pwc_cmd_t;

  typedef struct packed {
    logic skip;
    logic sine;
    logic out_free;
  } pwc_sts_t;

  typedef logic [QTAB_BITS-1:0] qtab_t [0:TAB_N];

  // Quarter sine wave in Q1.30 from a truncated integer Taylor series.
  function automatic qtab_t build_qtab();
    qtab_t              tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    for (int i = 0; i <= TAB_N; i++) begin
      x   = (HALF_PI_Q30 * 64'(i)) / TAB_N;
      x2  = (x * x) >> 30;
      t   = x;
      sum = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > $signed(ONE_Q30)) begin
        sum = $signed(ONE_Q30);
      end
      tab[i] = sum[QTAB_BITS-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QUARTER_TAB = build_qtab();

endpackage

`default_nettype wire

### src/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl
// Sequencer for the waveform cycler: accepts an item, steps the datapath
// through saturation, serial division, shaping and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_ctrl
  import pwc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pwc_sts_t sts,
  output pwc_cmd_t ctl
);

  localparam int CNT_BITS = $clog2(FRAC_BITS);

  pwc_state_t          state_r;
  pwc_state_t          state_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        ctl.sat   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.skip ? ST_COMMIT : ST_DIV;
      end
      ST_DIV: begin
        ctl.div = 1'b1;
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(FRAC_BITS - 1)) begin
          state_nxt = ST_QUAD;
        end
      end
      ST_QUAD: begin
        ctl.quad  = 1'b1;
        state_nxt = sts.sine ? ST_TAB : ST_TERM;
      end
      ST_TAB: begin
        ctl.tab   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_SIN;
      end
      ST_SIN: begin
        ctl.sin   = 1'b1;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        ctl.term  = 1'b1;
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        ctl.level = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The result waits here until the output register is free.
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/pwc_datapath.sv
// ----------------------------------------------------------------------------
// pwc_datapath
// Configuration registers, phase state, restoring divider, sine interpolation
// and level arithmetic of the waveform cycler.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_datapath
  import pwc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pwc_cmd_t                 ctl,
  output pwc_sts_t                 sts,
  input  pwc_in_t                  in_data,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output pwc_out_t                 out_data
);

  localparam int V         = VALUE_BITS;
  localparam int T         = TIME_BITS;
  localparam int F         = FRAC_BITS;
  localparam int S         = SINE_TABLE_BITS;
  localparam int R         = F - 2;
  localparam int M_BITS    = F + 1;
  localparam int FINE_BITS = R + 1 + S;
  localparam int IDX_BITS  = S + 1;
  localparam int D_BITS    = QTAB_BITS + 1;
  localparam int PROD_BITS = D_BITS + R + 1;
  localparam int FB        = QTAB_BITS + 2;
  localparam int U_BITS    = FB - 1;
  localparam int STEP_BITS = V + 1;
  localparam int TP_BITS   = STEP_BITS + M_BITS + 1;

  localparam logic signed [FB-1:0]      ONE_F  = FB'(ONE_Q30);
  localparam logic [U_BITS-1:0]         RND_U  = U_BITS'(1) << (29 - F);
  localparam logic signed [TP_BITS-1:0] HALF_T = TP_BITS'(1) << (F - 1);

  // Configuration registers.
  logic signed [V-1:0] start_r;
  logic signed [V-1:0] end_r;
  logic [T-1:0]        period_r;
  logic [2:0]          wave_r;
  logic                enable_r;

  // Phase state.
  logic [T-1:0]        elapsed_r;
  logic                desc_r;
  logic signed [V-1:0] level_r;

  // Per-item working registers.
  logic                        cmd_r;
  logic [T-1:0]                delta_r;
  logic [T-1:0]                sat_r;
  logic                        full_r;
  logic [T-1:0]                rem_r;
  logic [F-1:0]                quo_r;
  logic [1:0]                  q_r;
  logic [IDX_BITS-1:0]         idx_r;
  logic [R-1:0]                fr_r;
  logic [QTAB_BITS-1:0]        a_r;
  logic signed [D_BITS-1:0]    d_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [M_BITS-1:0]           mp_r;
  logic signed [TP_BITS-1:0]   tprod_r;
  logic signed [V-1:0]         newlvl_r;
  logic                        out_valid_r;
  pwc_out_t                    out_r;

  logic [T:0]                  sum_w;
  logic [T-1:0]                sat_w;
  logic [T:0]                  rem2_w;
  logic                        ge_w;
  logic [M_BITS-1:0]           m_w;
  logic                        qoff_w;
  logic [2:0]                  qsum_w;
  logic [1:0]                  q_w;
  logic [R:0]                  r_w;
  logic [FINE_BITS-1:0]        fine_w;
  logic                        at_end_w;
  logic [QTAB_BITS-1:0]        tab_a_w;
  logic [QTAB_BITS-1:0]        tab_b_w;
  logic signed [D_BITS-1:0]    d_w;
  logic signed [FB-1:0]        interp_w;
  logic signed [FB-1:0]        f_w;
  logic signed [FB-1:0]        fs_w;
  logic signed [FB-1:0]        usum_w;
  logic [U_BITS-1:0]           mrnd_w;
  logic signed [STEP_BITS-1:0] step_w;
  logic signed [TP_BITS-1:0]   trnd_w;
  logic signed [TP_BITS-1:0]   term_w;
  logic signed [TP_BITS-1:0]   up_w;
  logic signed [TP_BITS-1:0]   dn_w;
  logic signed [V-1:0]         shape_w;
  logic signed [V-1:0]         lvl_c;
  logic                        desc_c;
  logic [T-1:0]                elap_c;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      period_r <= '0;
      wave_r   <= WAVE_TRIANGLE;
      enable_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START:    start_r  <= cfg_data[V-1:0];
        REG_END:      end_r    <= cfg_data[V-1:0];
        REG_PERIOD:   period_r <= cfg_data[T-1:0];
        REG_WAVEFORM: wave_r   <= cfg_data[2:0];
        REG_ENABLE:   enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Elapsed time saturates at the period; a lowered period clips it too.
  assign sum_w = {1'b0, elapsed_r} + {1'b0, delta_r};
  assign sat_w = (sum_w >= {1'b0, period_r}) ? period_r : sum_w[T-1:0];

  // One quotient bit per divider step.
  assign rem2_w = {rem_r, 1'b0};
  assign ge_w   = (rem2_w >= {1'b0, period_r});

  // A full period, including a period of zero, gives the full fraction.
  assign m_w    = full_r ? {1'b1, {F{1'b0}}} : {1'b0, quo_r};
  assign qoff_w = (wave_r == WAVE_COSINE);
  assign qsum_w = m_w[F:R] + {2'b00, qoff_w};
  assign q_w    = qsum_w[1:0];
  assign r_w    = q_w[0] ? ({1'b1, {R{1'b0}}} - {1'b0, m_w[R-1:0]})
                         : {1'b0, m_w[R-1:0]};
  assign fine_w = {r_w, {S{1'b0}}};

  assign at_end_w = idx_r[S];
  assign tab_a_w  = QUARTER_TAB[idx_r];
  assign tab_b_w  = at_end_w ? tab_a_w : QUARTER_TAB[idx_r + IDX_BITS'(1)];
  assign d_w      = $signed({1'b0, tab_b_w}) - $signed({1'b0, tab_a_w});

  assign interp_w = FB'(prod_r >>> R);
  assign f_w      = $signed({2'b00, a_r}) + interp_w;
  assign fs_w     = q_r[1] ? -f_w : f_w;
  assign usum_w   = ONE_F + fs_w;
  assign mrnd_w   = usum_w[FB-1:1] + RND_U;

  assign step_w = $signed({end_r[V-1], end_r}) - $signed({start_r[V-1], start_r});
  assign trnd_w = tprod_r + HALF_T;
  assign term_w = trnd_w >>> F;
  assign up_w   = TP_BITS'(start_r) + term_w;
  assign dn_w   = TP_BITS'(end_r) - term_w;

  always_comb begin
    unique case (wave_r)
      WAVE_TRIANGLE: shape_w = desc_r ? dn_w[V-1:0] : up_w[V-1:0];
      WAVE_SINE:     shape_w = up_w[V-1:0];
      WAVE_COSINE:   shape_w = up_w[V-1:0];
      WAVE_SAWTOOTH: shape_w = up_w[V-1:0];
      WAVE_SQUARE:   shape_w = desc_r ? end_r : start_r;
      default:       shape_w = level_r;
    endcase
  end

  // Values written back at the end of an item.
  always_comb begin
    lvl_c  = level_r;
    desc_c = desc_r;
    elap_c = elapsed_r;
    if (cmd_r) begin
      lvl_c  = start_r;
      desc_c = 1'b0;
      elap_c = '0;
    end else if (enable_r) begin
      lvl_c  = newlvl_r;
      desc_c = desc_r ^ full_r;
      elap_c = full_r ? '0 : sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_data.cmd;
      delta_r <= in_data.delta;
    end
    if (ctl.sat) begin
      sat_r  <= sat_w;
      full_r <= (sat_w == period_r);
      rem_r  <= sat_w;
    end
    if (ctl.div) begin
      rem_r <= ge_w ? T'(rem2_w - {1'b0, period_r}) : rem2_w[T-1:0];
      quo_r <= {quo_r[F-2:0], ge_w};
    end
    if (ctl.quad) begin
      q_r   <= q_w;
      idx_r <= fine_w[FINE_BITS-1:R];
      fr_r  <= fine_w[R-1:0];
      mp_r  <= m_w;
    end
    if (ctl.tab) begin
      a_r <= tab_a_w;
      d_r <= d_w;
    end
    if (ctl.mul) begin
      prod_r <= d_r * $signed({1'b0, fr_r});
    end
    if (ctl.sin) begin
      mp_r <= mrnd_w[(30 - F) +: M_BITS];
    end
    if (ctl.term) begin
      tprod_r <= step_w * $signed({1'b0, mp_r});
    end
    if (ctl.level) begin
      newlvl_r <= shape_w;
    end
    if (ctl.commit) begin
      out_r.level   <= lvl_c;
      out_r.falling <= desc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      desc_r      <= 1'b0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        elapsed_r   <= elap_c;
        desc_r      <= desc_c;
        level_r     <= lvl_c;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.skip     = cmd_r || !enable_r;
  assign sts.sine     = (wave_r == WAVE_SINE) || (wave_r == WAVE_COSINE);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/periodic_waveform_cycler.sv
// A tick is saturated, divided, split by quadrant, table-interpolated (sine and
// cosine only), scaled and leveled, then written to the output register; a restart
// or disabled tick skips from saturation to write-back. A 16-step restoring divider
// forms the phase fraction. An item is taken only once the last is written back;
// a result can wait in the output register meanwhile. Synchronous active-low reset
// clears the phase, level and configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// periodic_waveform_cycler
// Low-frequency waveform generator: ticks advance the phase of a triangle,
// sine, cosine, sawtooth or square wave between two configured levels.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_waveform_cycler
  import pwc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pwc_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pwc_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  pwc_cmd_t ctl;
  pwc_sts_t sts;

  assign cfg_ready = 1'b1;

  pwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pwc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/pwc_checker.sv
// ----------------------------------------------------------------------------
// pwc_checker
// Port-level checks of the waveform cycler's handshakes and item sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_checker
  import pwc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pwc_out_t out_data
);

  // One item at a time: ready drops straight after an item is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is still in progress");

  // A new result only appears at the end of an item's processing.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in progress");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

endmodule

bind periodic_waveform_cycler pwc_checker u_pwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### bench/pwc_bench_pkg.sv
// ----------------------------------------------------------------------------
// pwc_bench_pkg
// Command and reserved-code constants shared by the waveform cycler bench.
// ----------------------------------------------------------------------------
`default_nettype none

package pwc_bench_pkg;

  // Input item commands.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Waveform codes with no shape behind them: the level holds.
  localparam logic [2:0] WAVE_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] WAVE_RESERVED_LAST  = 3'd7;

  // Register indexes that select no register.
  localparam int REG_RESERVED_FIRST = 5;
  localparam int REG_RESERVED_LAST  = 7;

endpackage

`default_nettype wire

### bench/pwc_wave_checker.sv
// ----------------------------------------------------------------------------
// pwc_wave_checker
// Watches the configuration, input and result channels of the waveform
// cycler, predicts the level and direction of every accepted item and
// compares each result with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module pwc_wave_checker
  import pwc_pkg::*;
  import pwc_bench_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  pwc_in_t                  in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  pwc_out_t                 out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       levels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     QSH   = FRAC_BITS - 2;
  localparam longint ONE_Q = longint'(1) << 30;

  longint                       qwave [0:TAB_N];
  logic signed [VALUE_BITS-1:0] start_lvl;
  logic signed [VALUE_BITS-1:0] end_lvl;
  logic [TIME_BITS-1:0]         period;
  logic [2:0]                   shape;
  logic                         enabled;
  logic [63:0]                  elapsed;
  logic                         descending;
  logic signed [VALUE_BITS-1:0] level_q;
  pwc_out_t                     levels_due [$];
  int                           errs = 0;

  // Quarter-wave entry in Q1.30: odd Taylor terms of sine, each one truncated.
  function automatic longint sine_entry(int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      acc;
    x   = (HALF_PI_Q30 * 64'(i)) / 64'(TAB_N);
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      acc = (k % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
    end
    if (acc < 0) begin
      acc = 0;
    end else if (acc > ONE_Q) begin
      acc = ONE_Q;
    end
    return acc;
  endfunction

  initial begin
    for (int i = 0; i <= TAB_N; i++) begin
      qwave[i] = sine_entry(i);
    end
  end

  // Rounded share of the step for a phase in Q1.16, with ties rounded towards plus infinity.
  function automatic longint round_term(longint step, longint m);
    return (step * m + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint quarter_sine(longint r);
    longint fine;
    longint idx;
    longint fr;
    longint a;
    longint d;
    fine = r << SINE_TABLE_BITS;
    idx  = fine >> QSH;
    fr   = fine & ((longint'(1) << QSH) - 1);
    if (idx >= TAB_N) begin
      return qwave[TAB_N];
    end
    a = qwave[int'(idx)];
    d = qwave[int'(idx) + 1] - a;
    return a + ((d * fr) >>> QSH);
  endfunction

  // Phase of the shaped wave, (f+1)/2 brought back to Q1.16.
  function automatic longint sine_phase(longint m, int qoff);
    int     q;
    longint r;
    longint f;
    longint u;
    q = int'(((m >> QSH) + qoff) & 3);
    r = m & ((longint'(1) << QSH) - 1);
    if (q[0]) begin
      r = (longint'(1) << QSH) - r;
    end
    f = quarter_sine(r);
    if (q[1]) begin
      f = -f;
    end
    u = (ONE_Q + f) >>> 1;
    return (u + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function automatic pwc_out_t next_level(pwc_in_t item);
    pwc_out_t res;
    longint   step;
    longint   m;
    longint   lvl;
    if (item.cmd == CMD_RESTART) begin
      elapsed    = '0;
      descending = 1'b0;
      level_q    = start_lvl;
    end else if (enabled) begin
      step    = longint'(end_lvl) - longint'(start_lvl);
      elapsed = elapsed + 64'(item.delta);
      if (elapsed >= 64'(period)) begin
        elapsed = 64'(period);
      end
      if (period == '0) begin
        m = longint'(1) << FRAC_BITS;
      end else begin
        m = longint'((elapsed << FRAC_BITS) / 64'(period));
      end
      lvl = longint'(level_q);
      case (shape)
        WAVE_TRIANGLE: begin
          lvl = descending ? longint'(end_lvl) - round_term(step, m)
                           : longint'(start_lvl) + round_term(step, m);
        end
        WAVE_SINE: begin
          lvl = longint'(start_lvl) + round_term(step, sine_phase(m, 0));
        end
        WAVE_COSINE: begin
          lvl = longint'(start_lvl) + round_term(step, sine_phase(m, 1));
        end
        WAVE_SAWTOOTH: begin
          lvl = longint'(start_lvl) + round_term(step, m);
        end
        WAVE_SQUARE: begin
          lvl = descending ? longint'(end_lvl) : longint'(start_lvl);
        end
        default: begin
        end
      endcase
      level_q = lvl[VALUE_BITS-1:0];
      if (elapsed == 64'(period)) begin
        elapsed    = '0;
        descending = ~descending;
      end
    end
    res.level   = level_q;
    res.falling = descending;
    return res;
  endfunction

  always @(posedge clk) begin
    pwc_out_t due;
    if (!rst_n) begin
      start_lvl  = '0;
      end_lvl    = '0;
      period     = '0;
      shape      = WAVE_TRIANGLE;
      enabled    = 1'b0;
      elapsed    = '0;
      descending = 1'b0;
      level_q    = '0;
      levels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START:    start_lvl = cfg_data[VALUE_BITS-1:0];
          REG_END:      end_lvl   = cfg_data[VALUE_BITS-1:0];
          REG_PERIOD:   period    = cfg_data[TIME_BITS-1:0];
          REG_WAVEFORM: shape     = cfg_data[2:0];
          REG_ENABLE:   enabled   = cfg_data[0];
          default: begin
          end
        endcase
      end
      // Results are matched before this edge's item is queued, so the oldest
      // prediction is always the one compared.
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $error("result with nothing outstanding: level %0d, falling %0b",
                 out_data.level, out_data.falling);
          errs++;
        end else begin
          due = levels_due.pop_front();
          if (out_data.level !== due.level) begin
            $error("level: expected %0d, got %0d", due.level, out_data.level);
            errs++;
          end
          if (out_data.falling !== due.falling) begin
            $error("falling: expected %0b, got %0b", due.falling, out_data.falling);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        levels_due.push_back(next_level(in_data));
      end
    end
    levels_pending <= levels_due.size();
    mismatches     <= errs;
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the waveform cycler with directed and random ticks, restarts and
// register settings under varying back-pressure, and reports the verdict
// from the failure count of the checker beside it.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwc_pkg::*;
  import pwc_bench_pkg::*;

  localparam int STALL_CYCLES = 400;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 25;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  pwc_in_t                  in_data   = '0;
  logic                     out_ready = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  wire                      in_ready;
  wire                      out_valid;
  wire                      cfg_ready;
  pwc_out_t                 out_data;

  int   mismatches;
  int   levels_pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic long_stall    = 1'b0;
  int   stall_count   = 0;

  always #5 clk = ~clk;

  periodic_waveform_cycler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwc_wave_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .levels_pending (levels_pending)
  );

  // Result side: random back-pressure, or one long hold-off while requested.
  always @(posedge clk) begin
    if (!long_stall) begin
      stall_count <= 0;
    end else if (stall_count < STALL_CYCLES) begin
      stall_count <= stall_count + 1;
    end
    if (long_stall && stall_count < STALL_CYCLES) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_item(logic cmd, logic [TIME_BITS-1:0] delta);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, delta: delta};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic set_wave(logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
                          logic [TIME_BITS-1:0] per, logic [2:0] shp, logic en);
    write_reg(REG_START, {(CFG_DATA_BITS - VALUE_BITS)'($urandom), lo});
    write_reg(REG_END, {(CFG_DATA_BITS - VALUE_BITS)'($urandom), hi});
    write_reg(REG_PERIOD, CFG_DATA_BITS'(per));
    write_reg(REG_WAVEFORM, {(CFG_DATA_BITS - 3)'($urandom), shp});
    write_reg(REG_ENABLE, {(CFG_DATA_BITS - 1)'($urandom), en});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_level();
    case ($urandom_range(5))
      0:       return {1'b1, {(VALUE_BITS - 1){1'b0}}};
      1:       return {1'b0, {(VALUE_BITS - 1){1'b1}}};
      2:       return '0;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Mostly short periods so that many periods end within one segment.
  function automatic logic [TIME_BITS-1:0] pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return TIME_BITS'($urandom);
      3, 4:    return TIME_BITS'($urandom_range(16, 1));
      default: return TIME_BITS'($urandom_range(4000, 1));
    endcase
  endfunction

  function automatic logic [2:0] pick_shape();
    if ($urandom_range(9) == 0) begin
      return 3'($urandom_range(WAVE_RESERVED_LAST, WAVE_RESERVED_FIRST));
    end
    return 3'($urandom_range(WAVE_SQUARE, WAVE_TRIANGLE));
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_delta(logic [TIME_BITS-1:0] per);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return TIME_BITS'($urandom);
      default: return TIME_BITS'($urandom_range(per / 3 + 1));
    endcase
  endfunction

  task automatic random_segment(int n);
    logic [TIME_BITS-1:0] per;
    per = pick_period();
    set_wave(pick_level(), pick_level(), per, pick_shape(), $urandom_range(7) != 0);
    repeat (n) begin
      send_item(($urandom_range(19) == 0) ? CMD_RESTART : CMD_TICK, pick_delta(per));
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset the block is disabled: ticks hold the zero level.
    send_item(CMD_TICK, '1);
    send_item(CMD_RESTART, TIME_BITS'($urandom));
    drain();

    for (int idx = REG_RESERVED_FIRST; idx <= REG_RESERVED_LAST; idx++) begin
      write_reg(CFG_IDX_BITS'(idx), CFG_DATA_BITS'($urandom));
    end
    set_wave(16'h8000, 16'h7FFF, 24'd100, WAVE_TRIANGLE, 1'b1);
    send_item(CMD_TICK, 24'd50);
    send_item(CMD_TICK, 24'd50);
    send_item(CMD_TICK, 24'd30);
    send_item(CMD_RESTART, 24'd0);
    drain();

    set_wave(16'h8000, 16'h7FFF, 24'd1000, WAVE_SINE, 1'b1);
    repeat (4) send_item(CMD_TICK, 24'd250);
    drain();

    set_wave(16'hC000, 16'h4000, 24'd1000, WAVE_COSINE, 1'b1);
    send_item(CMD_TICK, 24'd125);
    send_item(CMD_TICK, '1);
    drain();

    // Falling sawtooth with a negative step.
    set_wave(16'h7FFF, 16'h8000, 24'd7, WAVE_SAWTOOTH, 1'b1);
    send_item(CMD_TICK, 24'd3);
    send_item(CMD_TICK, 24'd4);
    drain();

    set_wave(16'h0123, 16'hFEDC, 24'd10, WAVE_SQUARE, 1'b1);
    send_item(CMD_TICK, 24'd10);
    send_item(CMD_TICK, 24'd5);
    drain();

    // A code with no shape holds the level while time still runs on.
    set_wave(16'h1000, 16'h2000, 24'd10, WAVE_RESERVED_FIRST, 1'b1);
    send_item(CMD_TICK, 24'd6);
    send_item(CMD_TICK, 24'd4);
    drain();

    // Zero period: every enabled tick ends a period at full phase.
    set_wave(16'hF000, 16'h0F00, 24'd0, WAVE_TRIANGLE, 1'b1);
    send_item(CMD_TICK, 24'd5);
    drain();

    // Elapsed time left above a newly lowered period saturates to it.
    set_wave(16'h0000, 16'h7000, 24'd1000, WAVE_SAWTOOTH, 1'b1);
    send_item(CMD_TICK, 24'd900);
    drain();
    set_wave(16'h0000, 16'h7000, 24'd100, WAVE_SAWTOOTH, 1'b1);
    send_item(CMD_TICK, 24'd0);
    drain();

    set_wave(16'h5555, 16'hAAAA, 24'd100, WAVE_TRIANGLE, 1'b0);
    send_item(CMD_TICK, 24'd50);
    send_item(CMD_RESTART, 24'd50);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct <= (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
      recv_idle_pct <= (phase == 0) ? 56 : (phase == 1) ? 16 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        // One long hold-off on the result side lets the block fill and stall.
        if (phase == 2 && seg == 0) begin
          long_stall <= 1'b1;
        end
        random_segment(SEG_ITEMS);
        if (phase == 2 && seg == 0) begin
          long_stall <= 1'b0;
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && levels_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
